// ===== hdl/adagrad_param_update_assert.svh =====
// Assertion macros used by the back part module.
`ifndef ADAGRAD_PARAM_UPDATE_ASSERT_SVH
`define ADAGRAD_PARAM_UPDATE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define AGU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the following cycle.
`define AGU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/agu_pkg.sv =====
package agu_pkg;

  localparam int unsigned MaxElementsDef = 4096;
  localparam int unsigned IdxW = 12;
  localparam int unsigned DataW = 32;
  localparam int unsigned AccW = 64;
  localparam int unsigned EpsW = 16;
  localparam int unsigned AddrW = 4;

  localparam logic [AddrW-1:0] RegInitRate = 4'h0;
  localparam logic [AddrW-1:0] RegDecay = 4'h4;
  localparam logic [AddrW-1:0] RegEps = 4'h8;

  localparam logic [DataW-1:0] InitRateRst = 32'd4294967;

  // Word passed from the front part to the back part.
  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] param;
    logic             gneg;
    logic [DataW-1:0] gmag;
    logic             last;
  } agu_word_t;

endpackage

// ===== hdl/agu_front.sv =====
module agu_front import agu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [IdxW-1:0]  element_index_i,
  input  logic [DataW-1:0] param_in_i,
  input  logic [DataW-1:0] gradient_i,
  input  logic             last_element_i,
  output logic             q_valid_o,
  input  logic             q_ready_i,
  output agu_word_t        q_word_o
);

  // Two-entry queue of classified words.
  agu_word_t  mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  agu_word_t  w;
  logic       push, pop;

  // Classify: split gradient into sign and magnitude.
  always_comb begin
    w.idx   = element_index_i;
    w.param = param_in_i;
    w.gneg  = gradient_i[DataW-1];
    w.gmag  = gradient_i[DataW-1] ? (~gradient_i + 1'b1) : gradient_i;
    w.last  = last_element_i;
  end

  assign ready_o   = (cnt_q != 2'd2);
  assign push      = valid_i && ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_word_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/agu_back.sv =====
`include "adagrad_param_update_assert.svh"
module agu_back import agu_pkg::*; #(
  parameter int unsigned MaxElements = MaxElementsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  agu_word_t        q_word_i,
  input  logic [DataW-1:0] rate_i,
  input  logic [EpsW-1:0]  eps_i,
  output logic             decay_o,
  output logic             clr_busy_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [IdxW-1:0]  element_index_out_o,
  output logic [DataW-1:0] param_out_o,
  output logic             saturated_o
);

  localparam int unsigned SlotW = (MaxElements > 1) ? $clog2(MaxElements) : 1;
  localparam int unsigned SlotCW = SlotW + 1;
  // Index folding by reciprocal multiplication; exact for 12-bit indexes.
  localparam bit          IdxFits = (MaxElements >= (1 << IdxW));
  localparam int unsigned RecipSh = 24;
  localparam int unsigned RecipW = RecipSh + 1;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << RecipSh) + 64'(MaxElements) - 64'd1) / 64'(MaxElements));

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_IDX, S_RD, S_SQ, S_ACC, S_ROOT, S_DEN, S_NUM, S_DIV, S_RES, S_OUT
  } state_e;

  state_e             st_q;
  logic [AccW-1:0]    mem [MaxElements];
  logic [AccW-1:0]    rd_q;
  logic [SlotCW-1:0]  clr_q;
  logic [SlotW-1:0]   slot_q;
  logic [IdxW+RecipW-1:0] qmul_q;
  agu_word_t          w_q;
  logic [AccW-1:0]    sq_q, acc_q, rem_q;
  logic [33:0]        root_q;
  logic [5:0]         cnt_q;
  logic [32:0]        den_q;
  logic [63:0]        num_q, quo_q;
  logic [48:0]        dr_q;
  logic               sat_q;
  logic [33:0]        res_q;

  logic [AccW:0]      acc_sum;
  logic [AccW-1:0]    rem_sh;
  logic [35:0]        trial;
  logic [64:0]        dr_sh;
  logic [33:0]        res_sum;
  logic [IdxW-1:0]    quot;
  logic [IdxW-1:0]    slot_rem;

  assign clr_busy_o = (st_q == S_CLR);
  assign q_ready_o  = (st_q == S_IDLE);
  assign acc_sum    = {1'b0, rd_q} + {1'b0, sq_q};
  // Fold the index into the store range.
  assign quot       = qmul_q[IdxW+RecipSh-1:RecipSh];
  assign slot_rem   = w_q.idx - quot * IdxW'(MaxElements);
  // Root digit step: bring down two bits, try 4*root+1.
  assign rem_sh     = {rem_q[AccW-3:0], acc_q[AccW-1:AccW-2]};
  assign trial      = {root_q, 2'b01};
  // Divide step: shift in one numerator bit.
  assign dr_sh      = {15'b0, dr_q, num_q[63]};
  assign res_sum    = w_q.gneg ? ({{2{w_q.param[31]}}, w_q.param} + {1'b0, quo_q[32:0]})
                               : ({{2{w_q.param[31]}}, w_q.param} - {1'b0, quo_q[32:0]});

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (st_q == S_CLR) begin
      mem[clr_q[SlotW-1:0]] <= '0;
    end else if (st_q == S_ACC) begin
      mem[slot_q] <= acc_sum[AccW] ? '1 : acc_sum[AccW-1:0];
    end
    rd_q <= mem[slot_q];
  end

  // Sequencer: clear, fold, read, accumulate, bit-serial root and divide, output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_CLR;
      clr_q   <= '0;
      valid_o <= 1'b0;
      decay_o <= 1'b0;
      slot_q  <= '0;
      qmul_q  <= '0;
      cnt_q   <= '0;
      sat_q   <= 1'b0;
      w_q     <= '0;
      sq_q    <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      root_q  <= '0;
      den_q   <= '0;
      num_q   <= '0;
      quo_q   <= '0;
      dr_q    <= '0;
      res_q   <= '0;
      element_index_out_o <= '0;
      param_out_o <= '0;
      saturated_o <= 1'b0;
    end else begin
      decay_o <= (st_q == S_OUT) && !valid_o && w_q.last;
      case (st_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == SlotCW'(MaxElements - 1)) st_q <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid_i) begin
            w_q    <= q_word_i;
            qmul_q <= {{RecipW{1'b0}}, q_word_i.idx} * {{IdxW{1'b0}}, Recip};
            st_q   <= S_IDX;
          end
        end
        S_IDX: begin
          slot_q <= IdxFits ? SlotW'(w_q.idx) : SlotW'(slot_rem);
          st_q   <= S_RD;
        end
        S_RD: begin
          sq_q <= {32'b0, w_q.gmag} * {32'b0, w_q.gmag};
          st_q <= S_SQ;
        end
        S_SQ: st_q <= S_ACC;
        S_ACC: begin
          sat_q  <= acc_sum[AccW];
          acc_q  <= acc_sum[AccW] ? '1 : acc_sum[AccW-1:0];
          rem_q  <= '0;
          root_q <= '0;
          cnt_q  <= '0;
          st_q   <= S_ROOT;
        end
        S_ROOT: begin
          acc_q <= {acc_q[AccW-3:0], 2'b00};
          if (rem_sh >= {28'b0, trial}) begin
            rem_q  <= rem_sh - AccW'(trial);
            root_q <= {root_q[32:0], 1'b1};
          end else begin
            rem_q  <= rem_sh;
            root_q <= {root_q[32:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'd31) st_q <= S_DEN;
        end
        S_DEN: begin
          den_q <= root_q[32:0] + {17'b0, eps_i};
          num_q <= {32'b0, rate_i} * {32'b0, w_q.gmag};
          st_q  <= S_NUM;
        end
        S_NUM: begin
          dr_q  <= '0;
          quo_q <= '0;
          cnt_q <= '0;
          st_q  <= (den_q == '0) ? S_RES : S_DIV;
        end
        S_DIV: begin
          num_q <= {num_q[62:0], 1'b0};
          if (dr_sh >= {16'b0, den_q, 16'b0}) begin
            dr_q  <= 49'(dr_sh - {16'b0, den_q, 16'b0});
            quo_q <= {quo_q[62:0], 1'b1};
          end else begin
            dr_q  <= dr_sh[48:0];
            quo_q <= {quo_q[62:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'd63) st_q <= S_RES;
        end
        S_RES: begin
          // Step is below 2^16 since the root is at least the gradient magnitude.
          res_q <= res_sum;
          st_q  <= S_OUT;
        end
        S_OUT: begin
          if (!valid_o) begin
            element_index_out_o <= w_q.idx;
            if ($signed(res_q) > 34'sh07FFFFFFF) begin
              param_out_o <= 32'h7FFFFFFF;
              saturated_o <= 1'b1;
            end else if ($signed(res_q) < -34'sh080000000) begin
              param_out_o <= 32'h80000000;
              saturated_o <= 1'b1;
            end else begin
              param_out_o <= res_q[31:0];
              saturated_o <= sat_q;
            end
            valid_o <= 1'b1;
            st_q    <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
      if (valid_o && ready_i) valid_o <= 1'b0;
    end
  end

  `AGU_ASSERT_IMP(a_no_take_in_clr, clk_i, rst_ni, clr_busy_o, !q_ready_o)
  `AGU_ASSERT_NEXT(a_decay_with_out, clk_i, rst_ni, decay_o, 1'b1)
  `AGU_ASSERT_IMP(a_decay_valid, clk_i, rst_ni, decay_o, valid_o)

endmodule

// ===== hdl/adagrad_param_update.sv =====
// An accepted input word waits in the two-entry front queue; the back part then folds
// its index, reads and accumulates, takes the square root and divides, and skips the
// divide when the denominator is zero. It takes a new word only once it has registered
// the last result word, paced by the 32-step square root and the 64-step divider; a
// result word left waiting holds the back part. Reset: asynchronous, active low; then
// a clearing pass zeroes the accumulator memory, and no input word is taken during it.
module adagrad_param_update import agu_pkg::*; #(
  parameter int unsigned MaxElements = MaxElementsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [IdxW-1:0]  element_index_i,
  input  logic [DataW-1:0] param_in_i,
  input  logic [DataW-1:0] gradient_i,
  input  logic             last_element_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [IdxW-1:0]  element_index_out_o,
  output logic [DataW-1:0] param_out_o,
  output logic             saturated_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [DataW-1:0] init_q, decay_q, rate_q;
  logic [EpsW-1:0]  eps_q;
  logic             wr, decay_ev, clr_busy;
  logic             fr_ready, qv, qr;
  agu_word_t        qw;
  logic [63:0]      prod;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign ready_o = fr_ready && !clr_busy;
  assign prod    = {32'b0, rate_q} * ({31'b0, 1'b1, 32'b0} - {32'b0, decay_q});

  // Register read mux.
  always_comb begin
    case (paddr)
      RegInitRate: prdata = init_q;
      RegDecay:    prdata = decay_q;
      RegEps:      prdata = {16'b0, eps_q};
      default:     prdata = '0;
    endcase
  end

  // Hold configuration; scale rate after the last word of a pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q  <= InitRateRst;
      decay_q <= '0;
      eps_q   <= 16'd1;
      rate_q  <= InitRateRst;
    end else begin
      if (wr && paddr == RegInitRate) begin
        init_q <= pwdata;
        rate_q <= pwdata;
      end else if (decay_ev) begin
        rate_q <= prod[63:32];
      end
      if (wr && paddr == RegDecay) decay_q <= pwdata;
      if (wr && paddr == RegEps) eps_q <= pwdata[15:0];
    end
  end

  agu_front u_front (
    .clk_i, .rst_ni,
    .valid_i(valid_i && !clr_busy), .ready_o(fr_ready),
    .element_index_i, .param_in_i, .gradient_i, .last_element_i,
    .q_valid_o(qv), .q_ready_i(qr), .q_word_o(qw)
  );

  agu_back #(.MaxElements(MaxElements)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(qv), .q_ready_o(qr), .q_word_i(qw),
    .rate_i(rate_q), .eps_i(eps_q),
    .decay_o(decay_ev), .clr_busy_o(clr_busy),
    .valid_o, .ready_i,
    .element_index_out_o, .param_out_o, .saturated_o
  );

endmodule

// ===== dv/adagrad_param_update_checker.sv =====
`timescale 1ns / 1ps
module adagrad_param_update_checker import agu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic             ready_o,
  input  logic [IdxW-1:0]  element_index_i,
  input  logic [DataW-1:0] param_in_i,
  input  logic [DataW-1:0] gradient_i,
  input  logic             last_element_i,
  input  logic             valid_o,
  input  logic             ready_i,
  input  logic [IdxW-1:0]  element_index_out_o,
  input  logic [DataW-1:0] param_out_o,
  input  logic             saturated_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] param;
    logic             sat;
  } update_t;

  logic [AccW-1:0]  sq_acc [MaxElementsDef];
  logic [DataW-1:0] rate_q, init_rate_q, decay_q;
  logic [EpsW-1:0]  eps_q;
  update_t          updates_q [$];
  int               fails;

  assign fail_count_o = fails;
  assign pending_o    = updates_q.size();

  function automatic logic [AccW-1:0] int_sqrt(logic [AccW-1:0] v);
    logic [AccW-1:0] root;
    logic [AccW-1:0] bit_w;
    root  = '0;
    bit_w = 64'h1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= root + bit_w) begin
        v    = v - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  // Predict one update and advance the accumulator and rate.
  task automatic predict_update();
    logic [11:0]      slot;
    logic [31:0]      gmag;
    logic             gneg;
    logic [64:0]      sum;
    logic [AccW-1:0]  acc;
    logic [AccW-1:0]  denom;
    logic [AccW-1:0]  num;
    logic [AccW-1:0]  stepmag;
    logic signed [63:0] res;
    logic [63:0]      keep;
    logic [63:0]      prod;
    update_t          u;
    u.sat = 1'b0;
    slot  = element_index_i % MaxElementsDef;
    gneg  = gradient_i[31];
    gmag  = gneg ? (~gradient_i + 32'd1) : gradient_i;
    sum   = {1'b0, sq_acc[slot]} + {33'd0, gmag} * {33'd0, gmag};
    if (sum[64]) begin
      acc   = '1;
      u.sat = 1'b1;
    end else begin
      acc = sum[63:0];
    end
    sq_acc[slot] = acc;
    denom = int_sqrt(acc) + {48'd0, eps_q};
    num   = {32'd0, rate_q} * {32'd0, gmag};
    stepmag = (denom == 0) ? 64'd0 : num / (denom << 16);
    res = gneg ? $signed({{32{param_in_i[31]}}, param_in_i}) + $signed(stepmag)
               : $signed({{32{param_in_i[31]}}, param_in_i}) - $signed(stepmag);
    if (res > 64'sd2147483647) begin
      res = 64'sd2147483647;
      u.sat = 1'b1;
    end else if (res < -64'sd2147483648) begin
      res = -64'sd2147483648;
      u.sat = 1'b1;
    end
    if (last_element_i) begin
      keep   = (64'd1 << 32) - {32'd0, decay_q};
      prod   = {32'd0, rate_q} * keep;
      rate_q = prod[63:32];
    end
    u.idx   = element_index_i;
    u.param = res[31:0];
    updates_q.push_back(u);
  endtask

  // Watch config, input and output words.
  always @(posedge clk_i or negedge rst_ni) begin
    update_t exp_u;
    if (!rst_ni) begin
      foreach (sq_acc[i]) sq_acc[i] = '0;
      init_rate_q = InitRateRst;
      rate_q      = InitRateRst;
      decay_q     = '0;
      eps_q       = 16'd1;
      updates_q.delete();
      fails       = 0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr)
          RegInitRate: begin
            init_rate_q = pwdata;
            rate_q      = pwdata;
          end
          RegDecay: decay_q = pwdata;
          RegEps:   eps_q   = pwdata[EpsW-1:0];
          default: ;
        endcase
      end
      if (valid_o && ready_i) begin
        if (updates_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result word idx=%0d", element_index_out_o);
        end else begin
          exp_u = updates_q.pop_front();
          if (exp_u.idx !== element_index_out_o || exp_u.param !== param_out_o ||
              exp_u.sat !== saturated_o) begin
            fails++;
            if (fails <= 10)
              $display("mismatch exp idx=%0d p=%h s=%b got idx=%0d p=%h s=%b",
                       exp_u.idx, exp_u.param, exp_u.sat,
                       element_index_out_o, param_out_o, saturated_o);
          end
        end
      end
      if (valid_i && ready_o) predict_update();
    end
  end

endmodule

// ===== dv/adagrad_param_update_tb.sv =====
`timescale 1ns / 1ps
module adagrad_param_update_tb;
  import agu_pkg::*;

  localparam int unsigned StallLimit = 20000;

  logic             clk, rst_n;
  logic             valid_in, ready_in, valid_out, ready_out;
  logic [IdxW-1:0]  idx, idx_out;
  logic [DataW-1:0] param, grad, param_out;
  logic             last, sat;
  logic             psel, penable, pwrite, pready;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata, prdata;
  int               fail_count, pending;
  int               send_idle, recv_idle;
  int unsigned      quiet_cycles;

  adagrad_param_update i_dut (
    .clk_i(clk), .rst_ni(rst_n), .valid_i(valid_in), .ready_o(ready_in),
    .element_index_i(idx), .param_in_i(param), .gradient_i(grad),
    .last_element_i(last), .valid_o(valid_out), .ready_i(ready_out),
    .element_index_out_o(idx_out), .param_out_o(param_out), .saturated_o(sat),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  adagrad_param_update_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n), .valid_i(valid_in), .ready_o(ready_in),
    .element_index_i(idx), .param_in_i(param), .gradient_i(grad),
    .last_element_i(last), .valid_o(valid_out), .ready_i(ready_out),
    .element_index_out_o(idx_out), .param_out_o(param_out), .saturated_o(sat),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: end the run when no word moves for too long.
  always @(posedge clk) begin
    if ((valid_in && ready_in) || (valid_out && ready_out) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver stalls at random.
  always @(negedge clk) begin
    ready_out <= ($urandom_range(99) >= recv_idle);
  end

  task automatic reg_write(logic [AddrW-1:0] addr, logic [31:0] data);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Present one word, hold until accepted.
  task automatic send_word(logic [11:0] i, logic [31:0] p, logic [31:0] g, logic l);
    if ($urandom_range(99) < send_idle) begin
      valid_in <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle) @(negedge clk);
    end
    valid_in <= 1'b1; idx <= i; param <= p; grad <= g; last <= l;
    do @(posedge clk); while (!ready_in);
    @(negedge clk);
  endtask

  // Drop valid, drain all expected results, then let the block settle.
  task automatic drain();
    valid_in <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  logic [31:0] rg;
  initial begin
    rst_n = 1'b0; valid_in = 1'b0;
    idx = '0; param = '0; grad = '0; last = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    send_idle = 30; recv_idle = 60;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes, saturation, wrap, decay at pass end.
    send_word(12'd0, 32'h0, 32'h0, 1'b0);
    send_word(12'd4095, 32'h7fffffff, 32'h80000000, 1'b0);
    send_word(12'd4095, 32'h80000000, 32'h7fffffff, 1'b0);
    send_word(12'd1, 32'h7fffffff, 32'hffffffff, 1'b1);
    send_word(12'd1, 32'h80000000, 32'h00000001, 1'b0);
    drain();
    reg_write(RegInitRate, 32'hffffffff);
    reg_write(RegDecay, 32'hffffffff);
    reg_write(RegEps, 32'h0000ffff);
    send_word(12'd7, 32'h80000000, 32'h00010000, 1'b1);
    send_word(12'd7, 32'h7fffffff, 32'hffff0000, 1'b0);
    send_word(12'd2, 32'h12345678, 32'h00000001, 1'b0);
    drain();
    // Zero epsilon on an empty entry: zero denominator.
    reg_write(RegEps, 32'h0);
    reg_write(RegInitRate, 32'h0);
    reg_write(RegDecay, 32'h0);
    send_word(12'd100, 32'h00010000, 32'h0, 1'b0);
    send_word(12'd100, 32'h00010000, 32'h00020000, 1'b0);
    drain();
    // Repeated huge gradients saturate the accumulator.
    reg_write(RegEps, 32'd1);
    reg_write(RegInitRate, 32'h80000000);
    reg_write(RegDecay, 32'h10000000);
    repeat (6) send_word(12'd55, 32'h0, 32'h80000000, 1'b1);
    drain();

    // Random phases with different idling and settings.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 30 : (ph == 1) ? 60 : 0;
      recv_idle = (ph == 0) ? 60 : (ph == 1) ? 30 : 0;
      reg_write(RegInitRate, $urandom());
      reg_write(RegDecay, (ph == 2) ? 32'h0 : $urandom() >> $urandom_range(31));
      reg_write(RegEps, $urandom_range(1, 65535));
      for (int n = 0; n < 160; n++) begin
        rg = $urandom();
        case ($urandom_range(3))
          0: rg = rg >> $urandom_range(31);
          1: rg = $signed(rg) >>> $urandom_range(31);
          default: ;
        endcase
        send_word(12'($urandom_range(3) == 0 ? $urandom() : $urandom_range(15)),
                  $urandom(), rg, $urandom_range(7) == 0);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
